### src/zpg_pkg.sv
// Shared types and constants for the zone penalty gradient block.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package zpg_pkg;

  // APB address width: four 32-bit registers at byte offsets 0..12
  localparam int AddrW = 4;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_ZONE_LOW     = 2'd0;
  localparam logic [1:0] REG_ZONE_HIGH    = 2'd1;
  localparam logic [1:0] REG_WEIGHT_BELOW = 2'd2;
  localparam logic [1:0] REG_WEIGHT_ABOVE = 2'd3;

  // Reset values of the configuration registers
  localparam logic signed [31:0] ZONE_LOW_RST     = 32'sd0;
  localparam logic signed [31:0] ZONE_HIGH_RST    = 32'sd0;
  localparam logic [15:0]        WEIGHT_BELOW_RST = 16'd256;
  localparam logic [15:0]        WEIGHT_ABOVE_RST = 16'd256;

  // Saturation ceiling of the running cost
  localparam logic [62:0] COST_MAX = {63{1'b1}};

  // Rounding offsets: gradient Q24.24 -> Q16.16 with x2, cost Q40.40 -> Q16.16
  localparam logic [48:0] GRAD_RND = 49'd64;
  localparam logic [48:0] COST_RND = 49'd8388608;

  typedef struct packed {
    logic signed [31:0] zone_low;
    logic signed [31:0] zone_high;
    logic [15:0]        weight_below;
    logic [15:0]        weight_above;
  } cfg_t;

  // Controller states, one-hot
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EVAL = 7'b0000010,
    S_M1   = 7'b0000100,
    S_M2   = 7'b0001000,
    S_M3   = 7'b0010000,
    S_M4   = 7'b0100000,
    S_ACC  = 7'b1000000
  } state_t;

  // Operand pairs of the shared 32x32 multiplier
  typedef enum logic [1:0] {
    MUL_Q_MAG   = 2'd0,  // weight * |error|
    MUL_MAG_MAG = 2'd1,  // |error| * |error|
    MUL_Q_E2LO  = 2'd2,  // weight * low word of error squared
    MUL_Q_E2HI  = 2'd3   // weight * high word of error squared
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;   // capture request payload
    logic     eval;      // compare with zone, register |error| and weight
    logic     mul_en;    // load product register
    mul_sel_t mul_sel;
    logic     grad_en;   // round and sign the gradient
    logic     e2hi_en;   // keep high word of error squared
    logic     plo_en;    // keep rounded low partial of the cost term
    logic     acc;       // accumulate cost and load the output register
  } cmd_t;

  typedef struct packed {
    logic out_free;      // output register can take a result this cycle
  } status_t;

endpackage

### src/zpg_regs.sv
// APB configuration registers: zone bounds and weights.
// Depends on zpg_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module zpg_regs import zpg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic       wr;
  logic [1:0] idx;

  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign pready = 1'b1;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zone_low     <= ZONE_LOW_RST;
      cfg.zone_high    <= ZONE_HIGH_RST;
      cfg.weight_below <= WEIGHT_BELOW_RST;
      cfg.weight_above <= WEIGHT_ABOVE_RST;
    end else if (wr) begin
      unique case (idx)
        REG_ZONE_LOW:     cfg.zone_low     <= pwdata;
        REG_ZONE_HIGH:    cfg.zone_high    <= pwdata;
        REG_WEIGHT_BELOW: cfg.weight_below <= pwdata[15:0];
        REG_WEIGHT_ABOVE: cfg.weight_above <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      REG_ZONE_LOW:     prdata = cfg.zone_low;
      REG_ZONE_HIGH:    prdata = cfg.zone_high;
      REG_WEIGHT_BELOW: prdata = {16'd0, cfg.weight_below};
      REG_WEIGHT_ABOVE: prdata = {16'd0, cfg.weight_above};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

### src/zpg_ctrl.sv
// Sequencer for one request: evaluate, four multiplier passes, accumulate.
// Depends on zpg_pkg for state_t, cmd_t and status_t.
`timescale 1ns / 1ps

module zpg_ctrl import zpg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   take;

  // Take a request when idle, or while the previous one retires
  assign in_stall = !((state == S_IDLE) || ((state == S_ACC) && st.out_free));
  assign take     = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (take) state_next = S_EVAL;
      S_EVAL: state_next = S_M1;
      S_M1:   state_next = S_M2;
      S_M2:   state_next = S_M3;
      S_M3:   state_next = S_M4;
      S_M4:   state_next = S_ACC;
      S_ACC: begin
        if (st.out_free) state_next = take ? S_EVAL : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode datapath commands from the state
  always_comb begin
    cmd         = '0;
    cmd.load_in = take;
    cmd.mul_sel = MUL_Q_MAG;
    unique case (state)
      S_EVAL: cmd.eval = 1'b1;
      S_M1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Q_MAG;
      end
      S_M2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MAG_MAG;
        cmd.grad_en = 1'b1;
      end
      S_M3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Q_E2LO;
        cmd.e2hi_en = 1'b1;
      end
      S_M4: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Q_E2HI;
        cmd.plo_en  = 1'b1;
      end
      S_ACC:  cmd.acc = st.out_free;
      default: ;
    endcase
  end

  // A request taken always starts evaluation next
  a_take_eval: assert property (@(posedge clk) disable iff (rst)
    take |=> state == S_EVAL)
    else $error("accepted request did not start evaluation");

  // A blocked retire holds in the accumulate state
  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && !st.out_free) |=> state == S_ACC)
    else $error("result dropped while output register busy");

  // Multiplier passes run without a gap
  a_m4_acc: assert property (@(posedge clk) disable iff (rst)
    state == S_M4 |=> state == S_ACC)
    else $error("multiplier sequence broken");

  // Accumulation only when the output register can take it
  a_acc_free: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |-> (state == S_ACC && st.out_free))
    else $error("accumulate issued outside retire");

endmodule

### src/zpg_dp.sv
// Datapath: zone compare, shared 32x32 multiplier, rounding, cost sum
// and output register. Depends on zpg_pkg for cfg_t, cmd_t, status_t.
`timescale 1ns / 1ps

module zpg_dp import zpg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  cmd_t                cmd,
  output status_t             st,
  input  logic signed [31:0]  predicted_value,
  input  logic                last_step,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [47:0]  gradient,
  output logic [62:0]         horizon_cost,
  output logic                run_end
);

  logic signed [31:0] y_r;
  logic               last_r;
  logic               neg_r;
  logic [31:0]        mag_r;
  logic [15:0]        q_r;
  logic [63:0]        p;
  logic [31:0]        e2hi;
  logic [24:0]        plo_sh;
  logic [47:0]        grad_r;
  logic [62:0]        cost_sum;

  // Capture request payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      y_r    <= predicted_value;
      last_r <= last_step;
    end
  end

  // Zone test; inside the zone weight and error go to zero
  logic signed [32:0] d_lo, d_hi, e_sel, e_abs;
  logic               below, above;

  assign below = y_r < cfg.zone_low;
  assign above = y_r > cfg.zone_high;
  assign d_lo  = 33'(y_r) - 33'(cfg.zone_low);
  assign d_hi  = 33'(y_r) - 33'(cfg.zone_high);

  always_comb begin
    if (below) begin
      e_sel = d_lo;
    end else if (above) begin
      e_sel = d_hi;
    end else begin
      e_sel = '0;
    end
    e_abs = e_sel[32] ? -e_sel : e_sel;
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      neg_r <= e_sel[32];
      mag_r <= e_abs[31:0];
      if (below) begin
        q_r <= cfg.weight_below;
      end else if (above) begin
        q_r <= cfg.weight_above;
      end else begin
        q_r <= 16'd0;
      end
    end
  end

  // Shared multiplier with registered product
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  always_comb begin
    case (cmd.mul_sel)
      MUL_Q_MAG: begin
        mul_a = {16'd0, q_r};
        mul_b = mag_r;
      end
      MUL_MAG_MAG: begin
        mul_a = mag_r;
        mul_b = mag_r;
      end
      MUL_Q_E2LO: begin
        mul_a = {16'd0, q_r};
        mul_b = p[31:0];
      end
      default: begin
        mul_a = {16'd0, q_r};
        mul_b = e2hi;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p <= prod;
    end
  end

  // Round the gradient half away from zero and apply the sign
  logic [48:0] g_sum;
  logic [47:0] g_mag;

  assign g_sum = {1'b0, p[47:0]} + GRAD_RND;
  assign g_mag = {6'd0, g_sum[48:7]};

  always_ff @(posedge clk) begin
    if (cmd.grad_en) begin
      grad_r <= neg_r ? (~g_mag + 48'd1) : g_mag;
    end
  end

  // Keep the high word of error squared and the rounded low partial
  logic [48:0] c_sum;

  assign c_sum = {1'b0, p[47:0]} + COST_RND;

  always_ff @(posedge clk) begin
    if (cmd.e2hi_en) begin
      e2hi <= p[63:32];
    end
    if (cmd.plo_en) begin
      plo_sh <= c_sum[48:24];
    end
  end

  // Add the step cost with saturation
  logic [56:0] term;
  logic [63:0] acc_sum;
  logic [62:0] cost_new;

  assign term     = {1'b0, p[47:0], 8'd0} + {32'd0, plo_sh};
  assign acc_sum  = {1'b0, cost_sum} + {7'd0, term};
  assign cost_new = acc_sum[63] ? COST_MAX : acc_sum[62:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cost_sum <= '0;
    end else if (cmd.acc) begin
      cost_sum <= last_r ? 63'd0 : cost_new;
    end
  end

  // Output register; a new result loads as the old one drains
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      gradient     <= grad_r;
      horizon_cost <= last_r ? cost_new : 63'd0;
      run_end      <= last_r;
    end
  end

  assign st.out_free = !out_valid || !out_stall;

  // The horizon's last step leaves the sum cleared
  a_clear_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.acc && last_r) |=> cost_sum == 63'd0)
    else $error("cost sum not cleared after last step");

  // Total cost shows only on a last-step result
  a_cost_on_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !run_end) |-> horizon_cost == 63'd0)
    else $error("total cost given on a non-final step");

endmodule

### src/zone_penalty_gradient_top.sv
// A request runs through the evaluate step and four passes through the single
// 32x32 multiplier, then retires into the output register. The next request is
// taken no earlier than the retire of the previous one; a held result stalls the
// next retire. Reset (rst, synchronous) clears the running cost, the output
// valid and the controller, and restores zone bounds to 0 and weights to 1.0.
// Depends on zpg_pkg, zpg_regs, zpg_ctrl and zpg_dp.
`timescale 1ns / 1ps

module zone_penalty_gradient_top import zpg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] predicted_value,
  input  logic               last_step,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] gradient,
  output logic [62:0]        horizon_cost,
  output logic               run_end
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;

  // Configuration registers
  zpg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  zpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Arithmetic and output register
  zpg_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .st              (st),
    .predicted_value (predicted_value),
    .last_step       (last_step),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .gradient        (gradient),
    .horizon_cost    (horizon_cost),
    .run_end         (run_end)
  );

endmodule

### tb/sv/tb_zone_penalty_gradient_top.sv
// Self-checking testbench for zone_penalty_gradient_top: APB setup, random
// requests with idle gaps and stalls, results checked against a scoreboard.
// Depends on zpg_pkg and the zone_penalty_gradient_top RTL.
`timescale 1ns / 1ps

module tb_zone_penalty_gradient_top;
  import zpg_pkg::*;

  localparam int CycleLimit = 400000;

  typedef struct {
    logic signed [47:0] gradient;
    logic [62:0]        horizon_cost;
    logic               run_end;
  } penalty_result_t;

  // Scoreboard: tracks zone configuration and running cost, queues predictions
  class penalty_scoreboard;
    logic signed [31:0] zone_low;
    logic signed [31:0] zone_high;
    logic [15:0]        weight_below;
    logic [15:0]        weight_above;
    logic [62:0]        cost_sum;
    penalty_result_t    awaited[$];
    int unsigned        errors;
    int unsigned        checked;

    function new();
      zone_low     = ZONE_LOW_RST;
      zone_high    = ZONE_HIGH_RST;
      weight_below = WEIGHT_BELOW_RST;
      weight_above = WEIGHT_ABOVE_RST;
      cost_sum     = '0;
      errors       = 0;
      checked      = 0;
    endfunction

    function void apply_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_ZONE_LOW:     zone_low = value;
        REG_ZONE_HIGH:    zone_high = value;
        REG_WEIGHT_BELOW: weight_below = value[15:0];
        REG_WEIGHT_ABOVE: weight_above = value[15:0];
        default: ;
      endcase
    endfunction

    // Predict gradient and horizon cost for one accepted request
    function void note_request(logic signed [31:0] y, logic last);
      logic signed [32:0] err;
      logic [31:0]        mag;
      logic [15:0]        q;
      logic [63:0]        grad_mag;
      logic [63:0]        err_sq;
      logic [79:0]        prod;
      logic [63:0]        term;
      logic [63:0]        sum;
      bit                 outside;
      penalty_result_t    res;
      outside = 1'b0;
      err = '0;
      q = '0;
      if (y < zone_low) begin
        outside = 1'b1;
        err = y - zone_low;
        q = weight_below;
      end else if (y > zone_high) begin
        outside = 1'b1;
        err = y - zone_high;
        q = weight_above;
      end
      res.gradient = '0;
      if (outside) begin
        mag = err[32] ? 32'(-err) : err[31:0];
        grad_mag = (64'(q) * 64'(mag) + 64'd64) >> 7;
        res.gradient = err[32] ? -$signed(48'(grad_mag)) : $signed(48'(grad_mag));
        err_sq = 64'(mag) * 64'(mag);
        prod = 80'(q) * 80'(err_sq) + 80'd8388608;
        term = 64'(prod >> 24);
        sum = {1'b0, cost_sum} + term;
        // saturate at the 63-bit ceiling, hold until the horizon ends
        if (sum > 64'(COST_MAX)) cost_sum = COST_MAX;
        else cost_sum = sum[62:0];
      end
      res.run_end = last;
      res.horizon_cost = last ? cost_sum : '0;
      if (last) cost_sum = '0;
      awaited.push_back(res);
    endfunction

    // Compare one retired result with the oldest prediction
    function void check_result(logic signed [47:0] grad, logic [62:0] cost, logic rend);
      penalty_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t ERROR unexpected result: gradient %0d horizon_cost %0d run_end %0b",
                 $time, grad, cost, rend);
        errors++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (grad !== want.gradient) begin
        $display("%0t ERROR gradient: expected %0d actual %0d", $time, want.gradient, grad);
        errors++;
      end
      if (cost !== want.horizon_cost) begin
        $display("%0t ERROR horizon_cost: expected %0d actual %0d",
                 $time, want.horizon_cost, cost);
        errors++;
      end
      if (rend !== want.run_end) begin
        $display("%0t ERROR run_end: expected %0b actual %0b", $time, want.run_end, rend);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [AddrW-1:0]         paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [31:0]       predicted_value;
  logic                     last_step;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [47:0]       gradient;
  logic [62:0]              horizon_cost;
  logic                     run_end;

  penalty_scoreboard sb = new();
  bit          quiet_in;
  bit          quiet_out;
  bit          hold_req;
  int unsigned sent;
  int unsigned horizons;
  int unsigned settings;

  zone_penalty_gradient_top uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .predicted_value(predicted_value), .last_step(last_step),
    .out_valid(out_valid), .out_stall(out_stall),
    .gradient(gradient), .horizon_cost(horizon_cost), .run_end(run_end)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("TIMEOUT after %0d cycles, %0d results still awaited", cycles, sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

  // Drive result-side stall: random, quiet, or a long counted hold-off
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 150;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet_out && ($urandom_range(0, 99) < 16);
      end
    end
  end

  // Check every retired result
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(gradient, horizon_cost, run_end);
  end

  // Offer one request, hold it until accepted, then log it
  task automatic send_req(input logic signed [31:0] y, input logic lst);
    if (!quiet_in && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    predicted_value <= y;
    last_step <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(y, lst);
    sent++;
    if (lst) horizons++;
  endtask

  // Drop valid and wait until every predicted result has retired
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.apply_reg(idx, value);
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [31:0] want,
                           input logic [31:0] mask);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== (want & mask)) begin
      $display("%0t ERROR register %0d readback: expected %h actual %h",
               $time, idx, want & mask, prdata & mask);
      sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write all four registers and read them back
  task automatic configure(input logic [31:0] lo, input logic [31:0] hi,
                           input logic [15:0] wb, input logic [15:0] wa);
    write_reg(REG_ZONE_LOW, lo);
    write_reg(REG_ZONE_HIGH, hi);
    write_reg(REG_WEIGHT_BELOW, {16'd0, wb});
    write_reg(REG_WEIGHT_ABOVE, {16'd0, wa});
    check_reg(REG_ZONE_LOW, lo, 32'hFFFF_FFFF);
    check_reg(REG_ZONE_HIGH, hi, 32'hFFFF_FFFF);
    check_reg(REG_WEIGHT_BELOW, {16'd0, wb}, 32'h0000_FFFF);
    check_reg(REG_WEIGHT_ABOVE, {16'd0, wa}, 32'h0000_FFFF);
    settings++;
  endtask

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] y;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    predicted_value = '0;
    last_step = 1'b0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    hold_req = 1'b0;
    sent = 0;
    horizons = 0;
    settings = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: zone of the single value zero, unit weights
    send_req(32'sh0001_0000, 1'b0);
    send_req(-32'sh0000_8000, 1'b0);
    send_req(32'sh0, 1'b1);
    drain();

    // Narrow zone, mixed weights; bounds, just outside, field extremes, rounding
    configure(-32'sh0001_8000, 32'sh0002_8000, 16'h0180, 16'h0001);
    send_req(32'sh8000_0000, 1'b0);
    send_req(32'sh7FFF_FFFF, 1'b0);
    send_req(-32'sh0001_8000, 1'b0);
    send_req(32'sh0002_8000, 1'b0);
    send_req(-32'sh0001_8001, 1'b0);
    send_req(32'sh0002_8001, 1'b0);
    send_req(32'sh0002_8040, 1'b0);
    send_req(32'sh0002_803F, 1'b0);
    send_req(32'sh0002_80C0, 1'b0);
    send_req(32'sh0000_0040, 1'b1);
    drain();

    // Inverted zone at the extremes, full weight below, none above
    configure(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'h0000);
    send_req(32'sh8000_0000, 1'b0);
    send_req(32'sh7FFF_FFFF, 1'b0);
    send_req(32'sh0, 1'b0);
    send_req(32'sh1234_5678, 1'b1);
    drain();

    // Zero weights on both sides
    configure(-32'sd5, 32'sd5, 16'h0000, 16'h0000);
    send_req(32'sh8000_0000, 1'b0);
    send_req(32'sh7FFF_FFFF, 1'b1);
    drain();

    // Long horizon of maximal errors drives the cost into saturation; meanwhile
    // hold the result side off so the block backs up into its request side
    configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
    quiet_in = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 150; i++) begin
      send_req(32'h8000_0000 | 32'($urandom_range(0, 255)), i == 149);
    end
    quiet_in = 1'b0;
    send_req(32'sh0, 1'b1);
    drain();

    // Random settings; the first one runs with no idling on either side
    for (int p = 0; p < 6; p++) begin
      lo = $urandom;
      case ($urandom_range(0, 3))
        0:       hi = lo;
        1:       hi = lo - 32'($urandom_range(1, 32'h0004_0000));
        2:       hi = $urandom;
        default: hi = lo + 32'($urandom_range(0, 32'h0004_0000));
      endcase
      configure(lo, hi, pick_weight(), pick_weight());
      quiet_in = (p == 0);
      quiet_out = (p == 0);
      for (int i = 0; i < 50; i++) begin
        case ($urandom_range(0, 3))
          0:       y = $urandom;
          1:       y = lo + 32'($urandom_range(0, 1023)) - 32'd512;
          2:       y = hi + 32'($urandom_range(0, 1023)) - 32'd512;
          default: y = lo + 32'($urandom_range(0, 32'h0001_FFFF)) - 32'h0000_FFFF;
        endcase
        send_req(y, $urandom_range(0, 7) == 0);
      end
      quiet_in = 1'b0;
      quiet_out = 1'b0;
      drain();
    end

    if (sb.pending() != 0) begin
      $display("%0t ERROR %0d results never retired", $time, sb.pending());
      sb.errors++;
    end
    $display("Sent %0d requests over %0d register settings, %0d horizons closed;",
             sent, settings, horizons);
    $display("checked %0d results incl. saturated cost and a long result hold-off",
             sb.checked);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### zone_penalty_gradient_top.f
src/zpg_pkg.sv
src/zpg_regs.sv
src/zpg_ctrl.sv
src/zpg_dp.sv
src/zone_penalty_gradient_top.sv
tb/sv/tb_zone_penalty_gradient_top.sv
